/* hw/rtl/ptbt_pkg.sv */
// Shared types and constants for the pan/tilt beacon tracker.
// Holds the fixed-point formats, the step-scaling constants, the register indexes and the
// per-axis command type. No dependencies; compiled before every other file.
package ptbt_pkg;

   // Widths of the fields and of the fixed-point positions
   localparam int POS_FRAC_BITS = 16;
   localparam int COORD_BITS    = 10;
   localparam int POS_W         = POS_FRAC_BITS + 1;
   localparam int DB_W          = 10;
   localparam int SWEEP_W       = 12;
   localparam int COUNT_W       = 8;
   localparam int STATUS_W      = 3;
   localparam int CSR_W         = 12;
   localparam int CSR_IDX_W     = 3;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_BAND     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_STEP    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_MISS_LIMIT    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_REPORT_PERIOD = CSR_IDX_W'(5);

   // Offsets are compared at a width that holds the coordinate, the dead band and 450
   localparam int CMP_W = (COORD_BITS > DB_W) ? COORD_BITS : DB_W;
   localparam logic [CMP_W-1:0] BIG_OFFSET = CMP_W'(450);

   // Proportional step: (mag * 2^F + 75000) / 150000 for mag up to 450.
   // The quotient is exact through a rounded-up reciprocal wide enough for every numerator.
   localparam int MAG_W       = 9;
   localparam int NUM_W       = MAG_W + POS_FRAC_BITS + 1;
   localparam int DIV_W       = 18;
   localparam longint unsigned STEP_DIV = 64'd150000;
   localparam logic [NUM_W-1:0] ROUND_ADD = NUM_W'(75000);
   localparam int RECIP_SHIFT = NUM_W + DIV_W;
   localparam int RECIP_W     = NUM_W + 1;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + STEP_DIV - 64'd1) / STEP_DIV);

   // Step magnitudes stay below 2^(F-7)
   localparam int STEP_W = POS_FRAC_BITS - 7;
   localparam logic [STEP_W-1:0] FIXED_STEP =
      STEP_W'((64'd5 * (64'd1 << POS_FRAC_BITS) + 64'd500) / 64'd1000);

   // Amount added to or taken from a position: a step or the sweep increment
   localparam int AMT_W = (STEP_W > SWEEP_W) ? STEP_W : SWEEP_W;

   // Position constants
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(64'd1 << POS_FRAC_BITS);
   localparam logic [POS_W-1:0] POS_HALF = POS_W'(64'd1 << (POS_FRAC_BITS - 1));
   localparam logic [POS_W-1:0] TILT_UP  =
      POS_W'((64'd3 * (64'd1 << POS_FRAC_BITS) + 64'd2) / 64'd5);
   localparam logic [POS_W-1:0] TILT_DOWN =
      POS_W'((64'd2 * (64'd1 << POS_FRAC_BITS) + 64'd2) / 64'd5);

   // Tracking status codes
   localparam logic [STATUS_W-1:0] ST_TRACKING = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_COUNTING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LOST     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SWEEPING = 3'd4;

   // Command for one axis: step magnitude, its direction and whether the servo is driven
   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              neg;
      logic              drive;
   } ptbt_axis_type;

endpackage

/* hw/rtl/ptbt_axis_step.sv */
// Per-axis offset evaluation for the beacon tracker.
// Turns a coordinate and an aim point into a step, its sign and a servo-drive flag.
// Depends on ptbt_pkg.
module ptbt_axis_step (
   input  logic [ptbt_pkg::COORD_BITS-1:0] coord,
   input  logic [ptbt_pkg::COORD_BITS-1:0] center,
   input  logic [ptbt_pkg::DB_W-1:0]       dead_band,
   output ptbt_pkg::ptbt_axis_type         cmd
);
   import ptbt_pkg::*;

   logic signed [COORD_BITS:0] diff;
   logic [COORD_BITS-1:0]      mag;
   logic [CMP_W-1:0]           mag_ext;
   logic                       big;
   logic [MAG_W-1:0]           mag_small;
   logic [NUM_W-1:0]           num;
   logic [PROD_W-1:0]          prod;
   logic [STEP_W-1:0]          prop_step;

   // Signed offset of the aim point from the coordinate, and its magnitude
   assign diff    = $signed({1'b0, center}) - $signed({1'b0, coord});
   assign mag     = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
   assign mag_ext = CMP_W'(mag);
   assign big     = mag_ext > BIG_OFFSET;

   // Rounded proportional step by multiplication with the reciprocal of 150000
   assign mag_small = mag_ext[MAG_W-1:0];
   assign num       = NUM_W'({mag_small, {POS_FRAC_BITS{1'b0}}}) + ROUND_ADD;
   assign prod      = PROD_W'(num) * PROD_W'(RECIP);
   assign prop_step = prod[RECIP_SHIFT +: STEP_W];

   // A large offset takes the fixed step
   assign cmd.step  = big ? FIXED_STEP : prop_step;
   assign cmd.neg   = diff[COORD_BITS];
   assign cmd.drive = mag_ext > CMP_W'(dead_band);

endmodule

/* hw/rtl/pan_tilt_beacon_tracker.sv */
// Pan/tilt beacon tracker: one blob coordinate pair per request, one servo command per request.
// The offset and step are registered in the first stage as the request is taken; the
// position update then loads the result register once it is free. One request is taken
// per cycle unless the receiver stalls; the result register lets a new request in while a
// finished result waits. Reset is synchronous and active high: it restores the register
// defaults, centres both servos, sets the sweep direction upwards and clears both counters.
module pan_tilt_beacon_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ptbt_pkg::COORD_BITS-1:0]   req_blob_x,
   input  logic [ptbt_pkg::COORD_BITS-1:0]   req_blob_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ptbt_pkg::POS_W-1:0]        rsp_pan_position,
   output logic [ptbt_pkg::POS_W-1:0]        rsp_tilt_position,
   output logic                              rsp_pan_write,
   output logic                              rsp_tilt_write,
   output logic [ptbt_pkg::STATUS_W-1:0]     rsp_track_status,
   output logic                              rsp_report_strobe,
   input  logic                              csr_write,
   input  logic [ptbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ptbt_pkg::CSR_W-1:0]        csr_wdata
);
   import ptbt_pkg::*;

   // Request classes held in the first stage
   localparam logic [1:0] KIND_TRACK  = 2'd0;
   localparam logic [1:0] KIND_ABSENT = 2'd1;
   localparam logic [1:0] KIND_MISS   = 2'd2;

   localparam int SUM_W = ((POS_W > AMT_W) ? POS_W : AMT_W) + 1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration registers
   logic [COORD_BITS-1:0] center_x_ff, center_y_ff;
   logic [DB_W-1:0]       dead_band_ff;
   logic [SWEEP_W-1:0]    sweep_step_ff;
   logic [COUNT_W-1:0]    miss_limit_ff, report_period_ff;

   // Tracker state
   logic [POS_W-1:0]   pan_pos_ff, pan_pos_in;
   logic [POS_W-1:0]   tilt_pos_ff, tilt_pos_in;
   logic               sweep_up_ff, sweep_up_in;
   logic [COUNT_W-1:0] miss_count_ff, miss_count_in;
   logic [COUNT_W-1:0] report_count_ff, report_count_in;

   // First stage
   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_kind_ff, s1_kind_in;
   ptbt_axis_type s1_pan_ff, s1_tilt_ff;
   ptbt_axis_type pan_cmd, tilt_cmd;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_pan_ff, rsp_tilt_ff;
   logic                rsp_pw_ff, rsp_tw_ff, rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                out_free, s1_take, s2_go;
   logic                pan_wr, tilt_wr, strobe;
   logic [STATUS_W-1:0] status;

   // Saturating position arithmetic
   function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] pos,
                                                input logic [AMT_W-1:0] amt);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(pos) + SUM_W'(amt);
      return (sum > SUM_W'(POS_ONE)) ? POS_ONE : sum[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] pos_sub(input logic [POS_W-1:0] pos,
                                                input logic [AMT_W-1:0] amt);
      logic [SUM_W-1:0] diff;
      diff = SUM_W'(pos) - SUM_W'(amt);
      return (SUM_W'(amt) > SUM_W'(pos)) ? '0 : diff[POS_W-1:0];
   endfunction

   // Handshake: the result register frees up when empty or taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_take   = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= COORD_BITS'(415);
         center_y_ff      <= COORD_BITS'(512);
         dead_band_ff     <= DB_W'(5);
         sweep_step_ff    <= SWEEP_W'(131);
         miss_limit_ff    <= COUNT_W'(200);
         report_period_ff <= COUNT_W'(200);
      end else if (csr_write) begin
         case (csr_index)
            REG_CENTER_X:      center_x_ff      <= csr_wdata[COORD_BITS-1:0];
            REG_CENTER_Y:      center_y_ff      <= csr_wdata[COORD_BITS-1:0];
            REG_DEAD_BAND:     dead_band_ff     <= csr_wdata[DB_W-1:0];
            REG_SWEEP_STEP:    sweep_step_ff    <= csr_wdata[SWEEP_W-1:0];
            REG_MISS_LIMIT:    miss_limit_ff    <= csr_wdata[COUNT_W-1:0];
            REG_REPORT_PERIOD: report_period_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Offset and step evaluation for each axis
   ptbt_axis_step u_pan_step (
      .coord     (req_blob_x),
      .center    (center_x_ff),
      .dead_band (dead_band_ff),
      .cmd       (pan_cmd)
   );

   ptbt_axis_step u_tilt_step (
      .coord     (req_blob_y),
      .center    (center_y_ff),
      .dead_band (dead_band_ff),
      .cmd       (tilt_cmd)
   );

   // Classify the request: sensor absent, no blob, or a blob to track
   always_comb begin
      if (req_blob_x == '0 && req_blob_y == '0) begin
         s1_kind_in = KIND_ABSENT;
      end else if (req_blob_x == '1 && req_blob_y == '1) begin
         s1_kind_in = KIND_MISS;
      end else begin
         s1_kind_in = KIND_TRACK;
      end
   end

   always_comb begin
      if (s1_take) begin
         s1_valid_in = 1'b1;
      end else if (s2_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_kind_ff <= s1_kind_in;
         s1_pan_ff  <= pan_cmd;
         s1_tilt_ff <= tilt_cmd;
      end
   end

   // Position, sweep and counter update for the request in the first stage
   always_comb begin
      pan_pos_in      = pan_pos_ff;
      tilt_pos_in     = tilt_pos_ff;
      sweep_up_in     = sweep_up_ff;
      miss_count_in   = miss_count_ff;
      report_count_in = report_count_ff;
      pan_wr          = 1'b0;
      tilt_wr         = 1'b0;
      strobe          = 1'b0;
      status          = ST_ABSENT;
      case (s1_kind_ff)
         KIND_ABSENT: begin
            status = ST_ABSENT;
         end
         KIND_MISS: begin
            if (miss_count_ff < miss_limit_ff) begin
               miss_count_in = miss_count_ff + 1'b1;
               status        = ST_COUNTING;
            end else if (miss_count_ff == miss_limit_ff) begin
               if (miss_count_ff != COUNT_MAX) begin
                  miss_count_in = miss_count_ff + 1'b1;
               end
               status = ST_LOST;
            end else begin
               if (sweep_up_ff) begin
                  tilt_pos_in = TILT_UP;
                  pan_pos_in  = pos_add(pan_pos_ff, AMT_W'(sweep_step_ff));
               end else begin
                  tilt_pos_in = TILT_DOWN;
                  pan_pos_in  = pos_sub(pan_pos_ff, AMT_W'(sweep_step_ff));
               end
               // Turn round at either end of travel
               if (pan_pos_in == '0) begin
                  sweep_up_in = 1'b1;
               end else if (pan_pos_in >= POS_ONE) begin
                  sweep_up_in = 1'b0;
               end
               pan_wr  = 1'b1;
               tilt_wr = 1'b1;
               status  = ST_SWEEPING;
            end
         end
         default: begin
            // Pan moves against the offset, tilt with it
            if (s1_pan_ff.neg) begin
               pan_pos_in = pos_add(pan_pos_ff, AMT_W'(s1_pan_ff.step));
            end else begin
               pan_pos_in = pos_sub(pan_pos_ff, AMT_W'(s1_pan_ff.step));
            end
            if (s1_tilt_ff.neg) begin
               tilt_pos_in = pos_sub(tilt_pos_ff, AMT_W'(s1_tilt_ff.step));
            end else begin
               tilt_pos_in = pos_add(tilt_pos_ff, AMT_W'(s1_tilt_ff.step));
            end
            pan_wr  = s1_pan_ff.drive;
            tilt_wr = s1_tilt_ff.drive;
            if (report_count_ff == report_period_ff) begin
               report_count_in = '0;
               strobe          = 1'b1;
            end else begin
               report_count_in = report_count_ff + 1'b1;
            end
            status = ST_TRACKING;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_pos_ff      <= POS_HALF;
         tilt_pos_ff     <= POS_HALF;
         sweep_up_ff     <= 1'b1;
         miss_count_ff   <= '0;
         report_count_ff <= '0;
      end else if (s2_go) begin
         pan_pos_ff      <= pan_pos_in;
         tilt_pos_ff     <= tilt_pos_in;
         sweep_up_ff     <= sweep_up_in;
         miss_count_ff   <= miss_count_in;
         report_count_ff <= report_count_in;
      end
   end

   // Result register
   always_comb begin
      if (s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsp_pan_ff    <= pan_pos_in;
         rsp_tilt_ff   <= tilt_pos_in;
         rsp_pw_ff     <= pan_wr;
         rsp_tw_ff     <= tilt_wr;
         rsp_status_ff <= status;
         rsp_strobe_ff <= strobe;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pan_position  = rsp_pan_ff;
   assign rsp_tilt_position = rsp_tilt_ff;
   assign rsp_pan_write     = rsp_pw_ff;
   assign rsp_tilt_write    = rsp_tw_ff;
   assign rsp_track_status  = rsp_status_ff;
   assign rsp_report_strobe = rsp_strobe_ff;

   // Positions never leave the range 0 to full travel.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pan_pos_ff <= POS_ONE && tilt_pos_ff <= POS_ONE)
      else $error("servo position beyond full travel");

   // The report strobe fires only on tracking results.
   a_strobe_tracking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_strobe_ff |-> rsp_status_ff == ST_TRACKING)
      else $error("report strobe outside tracking");

   // A sweeping result drives both servos.
   a_sweep_writes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_SWEEPING |-> rsp_pw_ff && rsp_tw_ff)
      else $error("sweep result without servo writes");

   // Only reset lowers the miss count.
   a_miss_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> miss_count_ff >= $past(miss_count_ff))
      else $error("miss count decreased");

   // Stalling the request side implies a request held in the first stage.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with nothing in flight");

endmodule

/* sim/pan_tilt_beacon_tracker_tb.sv */
// Self-checking testbench for pan_tilt_beacon_tracker: directed and random blob requests
// under random idling on both channels, with an in-bench predictor of the servo commands.
// Depends on ptbt_pkg and the pan_tilt_beacon_tracker RTL; needs no files or arguments.
module pan_tilt_beacon_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptbt_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int FULL_TRAVEL     = 1 << POS_FRAC_BITS;
   localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
   localparam int OFFSET_SPLIT    = 450;
   localparam int FIXED_STEP_Q    = (5 * FULL_TRAVEL + 500) / 1000;
   localparam int SWEEP_TILT_UP   = (3 * FULL_TRAVEL + 2) / 5;
   localparam int SWEEP_TILT_DOWN = (2 * FULL_TRAVEL + 2) / 5;

   typedef struct {
      logic [POS_W-1:0]    pan;
      logic [POS_W-1:0]    tilt;
      logic                pan_wr;
      logic                tilt_wr;
      logic [STATUS_W-1:0] status;
      logic                strobe;
   } servo_cmd_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COORD_BITS-1:0] req_blob_x = '0;
   logic [COORD_BITS-1:0] req_blob_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [POS_W-1:0]      rsp_pan_position;
   logic [POS_W-1:0]      rsp_tilt_position;
   logic                  rsp_pan_write;
   logic                  rsp_tilt_write;
   logic [STATUS_W-1:0]   rsp_track_status;
   logic                  rsp_report_strobe;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // Idling rates of the two channels, in percent of cycles
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   // Predictor copy of the configuration and of the tracker state
   int aim_x        = 415;
   int aim_y        = 512;
   int quiet_band   = 5;
   int sweep_inc    = 131;
   int lost_after   = 200;
   int strobe_every = 200;
   int pan_now      = FULL_TRAVEL / 2;
   int tilt_now     = FULL_TRAVEL / 2;
   bit sweep_rising = 1'b1;
   int miss_total   = 0;
   int report_ticks = 0;

   servo_cmd_type expected_cmds[$];

   pan_tilt_beacon_tracker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_blob_x        (req_blob_x),
      .req_blob_y        (req_blob_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pan_position  (rsp_pan_position),
      .rsp_tilt_position (rsp_tilt_position),
      .rsp_pan_write     (rsp_pan_write),
      .rsp_tilt_write    (rsp_tilt_write),
      .rsp_track_status  (rsp_track_status),
      .rsp_report_strobe (rsp_report_strobe),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver side: stall at random at the configured rate
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Run limit: well above the slowest correct run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("pan_tilt_beacon_tracker test failed");
      $finish;
   end

   function automatic int clamp_travel(input int v);
      if (v < 0) return 0;
      if (v > FULL_TRAVEL) return FULL_TRAVEL;
      return v;
   endfunction

   // Signed correction for one axis: proportional below the split, fixed above it
   function automatic int axis_step(input int d);
      longint mag;
      int     s;
      mag = (d < 0) ? -d : d;
      if (mag > OFFSET_SPLIT) s = FIXED_STEP_Q;
      else s = int'((mag * FULL_TRAVEL + 75000) / 150000);
      return (d < 0) ? -s : s;
   endfunction

   // Advances the predicted tracker state by one blob sample and returns the servo command
   function automatic servo_cmd_type track_blob(input int x, input int y);
      servo_cmd_type cmd;
      int            dx;
      int            dy;
      cmd.pan_wr  = 1'b0;
      cmd.tilt_wr = 1'b0;
      cmd.strobe  = 1'b0;
      if (x == 0 && y == 0) begin
         cmd.status = ST_ABSENT;
      end else if (x == COORD_MAX && y == COORD_MAX) begin
         if (miss_total < lost_after) begin
            miss_total++;
            cmd.status = ST_COUNTING;
         end else if (miss_total == lost_after) begin
            if (miss_total < 255) miss_total++;
            cmd.status = ST_LOST;
         end else begin
            // Sweep pan between the ends with tilt held at the level for the direction
            if (sweep_rising) begin
               tilt_now = SWEEP_TILT_UP;
               pan_now  = clamp_travel(pan_now + sweep_inc);
            end else begin
               tilt_now = SWEEP_TILT_DOWN;
               pan_now  = clamp_travel(pan_now - sweep_inc);
            end
            if (pan_now <= 0) sweep_rising = 1'b1;
            else if (pan_now >= FULL_TRAVEL) sweep_rising = 1'b0;
            cmd.pan_wr  = 1'b1;
            cmd.tilt_wr = 1'b1;
            cmd.status  = ST_SWEEPING;
         end
      end else begin
         dx = aim_x - x;
         dy = aim_y - y;
         pan_now  = clamp_travel(pan_now - axis_step(dx));
         tilt_now = clamp_travel(tilt_now + axis_step(dy));
         cmd.pan_wr  = (((dx < 0) ? -dx : dx) > quiet_band);
         cmd.tilt_wr = (((dy < 0) ? -dy : dy) > quiet_band);
         if (report_ticks == strobe_every) begin
            report_ticks = 0;
            cmd.strobe   = 1'b1;
         end else begin
            report_ticks = (report_ticks + 1) & 8'hFF;
         end
         cmd.status = ST_TRACKING;
      end
      cmd.pan  = POS_W'(pan_now);
      cmd.tilt = POS_W'(tilt_now);
      return cmd;
   endfunction

   // Each accepted result is compared with the oldest expected command
   always @(posedge clock) begin : check_results
      servo_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            $error("result arrived with no request outstanding");
            fail_count++;
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_pan_position !== want.pan) begin
               $error("pan_position: expected %0d, got %0d", want.pan, rsp_pan_position);
               fail_count++;
            end
            if (rsp_tilt_position !== want.tilt) begin
               $error("tilt_position: expected %0d, got %0d", want.tilt, rsp_tilt_position);
               fail_count++;
            end
            if (rsp_pan_write !== want.pan_wr) begin
               $error("pan_write: expected %0d, got %0d", want.pan_wr, rsp_pan_write);
               fail_count++;
            end
            if (rsp_tilt_write !== want.tilt_wr) begin
               $error("tilt_write: expected %0d, got %0d", want.tilt_wr, rsp_tilt_write);
               fail_count++;
            end
            if (rsp_track_status !== want.status) begin
               $error("track_status: expected %0d, got %0d", want.status, rsp_track_status);
               fail_count++;
            end
            if (rsp_report_strobe !== want.strobe) begin
               $error("report_strobe: expected %0d, got %0d", want.strobe, rsp_report_strobe);
               fail_count++;
            end
         end
      end
   end

   // Sends one blob request after a random gap and records its expected command
   task automatic send_blob(input int x, input int y);
      while ($urandom_range(99) < req_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_blob_x <= COORD_BITS'(x);
      req_blob_y <= COORD_BITS'(y);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_cmds.push_back(track_blob(x, y));
   endtask

   // Holds requests back until every outstanding result has been taken
   task automatic drain_tracker();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register; the bits above the field width carry random junk
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value, input int width);
      logic [CSR_W-1:0] word;
      word = CSR_W'(value) | (CSR_W'($urandom) << width);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      case (idx)
         REG_CENTER_X:      aim_x        = int'(word) & COORD_MAX;
         REG_CENTER_Y:      aim_y        = int'(word) & COORD_MAX;
         REG_DEAD_BAND:     quiet_band   = int'(word) & 10'h3FF;
         REG_SWEEP_STEP:    sweep_inc    = int'(word) & 12'hFFF;
         REG_MISS_LIMIT:    lost_after   = int'(word) & 8'hFF;
         REG_REPORT_PERIOD: strobe_every = int'(word) & 8'hFF;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure_tracker(input int cx, input int cy, input int db,
                                    input int sw, input int ml, input int rp);
      write_reg(REG_CENTER_X, cx, COORD_BITS);
      write_reg(REG_CENTER_Y, cy, COORD_BITS);
      write_reg(REG_DEAD_BAND, db, DB_W);
      write_reg(REG_SWEEP_STEP, sw, SWEEP_W);
      write_reg(REG_MISS_LIMIT, ml, COUNT_W);
      write_reg(REG_REPORT_PERIOD, rp, COUNT_W);
   endtask

   // Tracking at the reset settings: aim point, coordinate extremes, step split, dead band
   task automatic test_tracking_directed();
      req_gap_pct   = 38;
      rsp_stall_pct = 72;
      send_blob(415, 512);
      send_blob(0, 0);
      send_blob(COORD_MAX, COORD_MAX);
      send_blob(1, 1);
      send_blob(COORD_MAX, 0);
      send_blob(0, COORD_MAX);
      // Offsets of exactly 450 stay proportional, 451 takes the fixed step
      send_blob(865, 62);
      send_blob(866, 61);
      // Offsets at the dead band do not drive the servos, one beyond it does
      send_blob(420, 507);
      send_blob(421, 506);
      send_blob(COORD_MAX - 1, COORD_MAX);
      send_blob(COORD_MAX, COORD_MAX - 1);
   endtask

   // Lost report followed by a fast sweep that runs pan into full travel and turns back
   task automatic test_miss_and_sweep();
      drain_tracker();
      configure_tracker(415, 512, 5, 4095, 1, 200);
      repeat (12) send_blob(COORD_MAX, COORD_MAX);
   endtask

   // Random requests: mostly tracking and runs of misses, with absent and near-miss samples
   task automatic blob_traffic(input int n_items);
      int sent;
      int kind;
      int run;
      int off;
      int x;
      int y;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            case ($urandom_range(3))
               0: begin
                  x = $urandom_range(COORD_MAX);
                  y = $urandom_range(COORD_MAX);
               end
               1: begin
                  x = aim_x + $urandom_range(40) - 20;
                  y = aim_y + $urandom_range(40) - 20;
               end
               2: begin
                  x = $urandom_range(1) ? COORD_MAX - $urandom_range(1) : $urandom_range(1);
                  y = $urandom_range(1) ? COORD_MAX - $urandom_range(1) : $urandom_range(1);
               end
               default: begin
                  off = OFFSET_SPLIT - 1 + $urandom_range(3);
                  x   = $urandom_range(1) ? aim_x + off : aim_x - off;
                  off = OFFSET_SPLIT - 1 + $urandom_range(3);
                  y   = $urandom_range(1) ? aim_y + off : aim_y - off;
               end
            endcase
            if (x < 0) x = 0;
            if (x > COORD_MAX) x = COORD_MAX;
            if (y < 0) y = 0;
            if (y > COORD_MAX) y = COORD_MAX;
            send_blob(x, y);
            sent++;
         end else if (kind < 80) begin
            run = $urandom_range(40, 1);
            repeat (run) send_blob(COORD_MAX, COORD_MAX);
            sent += run;
         end else if (kind < 88) begin
            send_blob(0, 0);
            sent++;
         end else begin
            // One coordinate at a marker value, the other not at that value
            case ($urandom_range(3))
               0: send_blob(COORD_MAX, $urandom_range(COORD_MAX - 1));
               1: send_blob($urandom_range(COORD_MAX - 1), COORD_MAX);
               2: send_blob(0, $urandom_range(COORD_MAX, 1));
               default: send_blob($urandom_range(COORD_MAX, 1), 0);
            endcase
            sent++;
         end
      end
   endtask

   // Three idling regimes, two register settings each, including both extremes
   task automatic test_random_traffic();
      int k;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_gap_pct = 38; rsp_stall_pct = 72; end
            1: begin req_gap_pct = 72; rsp_stall_pct = 38; end
            default: begin req_gap_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (int set = 0; set < 2; set++) begin
            k = phase * 2 + set;
            drain_tracker();
            if (k == 0)
               configure_tracker($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                                 $urandom_range(40), $urandom_range(4095),
                                 $urandom_range(200, 120), $urandom_range(255));
            else if (k == 1)
               configure_tracker(COORD_MAX, COORD_MAX, 1023, 4095, 254, 255);
            else if (k == 3)
               configure_tracker(0, 0, 0, 0, 0, 0);
            else
               configure_tracker($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                                 $urandom_range(40), $urandom_range(4095),
                                 $urandom_range(60), $urandom_range(255));
            blob_traffic(170);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_tracking_directed();
      test_miss_and_sweep();
      test_random_traffic();
      drain_tracker();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("pan_tilt_beacon_tracker test passed");
      else
         $display("pan_tilt_beacon_tracker test failed");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/ptbt_pkg.sv
hw/rtl/ptbt_axis_step.sv
hw/rtl/pan_tilt_beacon_tracker.sv
sim/pan_tilt_beacon_tracker_tb.sv
